@@ hdl/bit_pkg.sv @@
// ----------------------------------------------------------------------------
// bit_pkg: shared types and constants for the binary image thinning block
// Command and status structs, state encoding and the 3x3 thinning table.
// ----------------------------------------------------------------------------
package bit_pkg;

	localparam int MaxWidth  = 64;
	localparam int MaxHeight = 64;
	localparam int IdxW      = 6;
	localparam int DimW      = 7;

	localparam logic [2:0] RegWidth  = 3'd0;
	localparam logic [2:0] RegHeight = 3'd4;

	typedef enum logic [1:0] {
		PH_NORTH = 2'd0,
		PH_SOUTH = 2'd1,
		PH_WEST  = 2'd2,
		PH_EAST  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROUND,
		ST_LINE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_RD_W,
		ST_EVAL,
		ST_NEXT,
		ST_PASS,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic             load_wr;
		logic             rd_a;      // read row (row_sel - 1)
		logic             rd_b;      // read row row_sel
		logic             rd_c;      // read row (row_sel + 1)
		logic             eval;      // evaluate pixel, clear if table says so
		logic             out_rd;    // fetch output row
		logic [IdxW-1:0]  row_sel;
		logic [IdxW-1:0]  col_sel;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic pix;        // center pixel value (from latched rows)
		logic cleared;    // evaluate cleared the pixel
	} dp_sts_t;

	localparam logic [7:0] LutRows [8][2] = '{
		'{8'b0011_0111, 8'b0010_0011},
		'{8'b1111_1111, 8'b0010_0010},
		'{8'b1111_1110, 8'b0010_0010},
		'{8'b1111_1111, 8'b1111_1111},
		'{8'b0011_0001, 8'b0011_0011},
		'{8'b1111_1111, 8'b0011_0011},
		'{8'b0011_0000, 8'b0000_0000},
		'{8'b0011_0000, 8'b0011_0011}
	};

	localparam logic [2:0] LutMap [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2,
		3'd4, 3'd5, 3'd6, 3'd6, 3'd7, 3'd5, 3'd6, 3'd6
	};

	function automatic logic lut_keep(input logic [7:0] code);
		logic [2:0]  r;
		logic [15:0] row;
		begin
			r   = LutMap[code[7:4]];
			row = {LutRows[r][1], LutRows[r][0]};
			lut_keep = row[code[3:0]];
		end
	endfunction

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
		input logic [DimW-1:0] hi);
		begin
			if (v < DimW'(3))
				clamp_dim = DimW'(3);
			else if (v > hi)
				clamp_dim = hi;
			else
				clamp_dim = v;
		end
	endfunction

endpackage

@@ hdl/bit_datapath.sv @@
// ----------------------------------------------------------------------------
// bit_datapath: pixel store and neighborhood evaluation
// Holds the image rows in a memory, latches three rows around the current
// pixel and applies the thinning table.
// ----------------------------------------------------------------------------
module bit_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bit_pkg::dp_cmd_t             cmd,
	input  logic [63:0]                  row_in,
	input  logic [63:0]                  mask,
	output bit_pkg::dp_sts_t             sts,
	output logic [63:0]                  out_row
);
	import bit_pkg::*;

	logic [63:0] mem [MaxHeight];
	logic [63:0] rd_q;
	logic [63:0] row_a_q, row_b_q, row_c_q;
	logic [IdxW-1:0] rsel_m1, rsel_p1, rd_addr;
	logic [IdxW-1:0] xm1, xp1, x;
	logic [7:0] code;
	logic        clr;
	logic        rd_pend_q;
	logic [1:0]  rd_which_q;

	assign rsel_m1 = cmd.row_sel - IdxW'(1);
	assign rsel_p1 = cmd.row_sel + IdxW'(1);
	assign x   = cmd.col_sel;
	assign xm1 = x - IdxW'(1);
	assign xp1 = x + IdxW'(1);

	always_comb begin
		rd_addr = cmd.row_sel;
		if (cmd.rd_a)
			rd_addr = rsel_m1;
		else if (cmd.rd_c)
			rd_addr = rsel_p1;
	end

	assign code = {row_a_q[x], row_a_q[xp1], row_b_q[xp1], row_c_q[xp1],
		row_c_q[x], row_c_q[xm1], row_b_q[xm1], row_a_q[xm1]};
	assign clr = cmd.eval && row_b_q[x] && !lut_keep(code);

	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			mem[cmd.row_sel] <= row_in & mask;
		else if (clr)
			mem[cmd.row_sel] <= row_b_q & ~(64'd1 << x);
		if (cmd.rd_a || cmd.rd_b || cmd.rd_c)
			rd_q <= mem[rd_addr];
	end

	// read data lands in rd_q in the cycle after the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q  <= 1'b0;
			rd_which_q <= 2'd0;
		end else begin
			rd_pend_q  <= cmd.rd_a | cmd.rd_b | cmd.rd_c;
			rd_which_q <= cmd.rd_a ? 2'd0 : (cmd.rd_b ? 2'd1 : 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			unique case (rd_which_q)
				2'd0:    row_a_q <= rd_q;
				2'd1:    row_b_q <= rd_q;
				default: row_c_q <= rd_q;
			endcase
		end else if (clr) begin
			row_b_q <= row_b_q & ~(64'd1 << x);
		end
	end

	assign sts.pix     = row_b_q[x];
	assign sts.cleared = clr;
	assign out_row     = rd_q & mask;

endmodule

@@ hdl/bit_ctrl.sv @@
// ----------------------------------------------------------------------------
// bit_ctrl: sequencer for loading, directional passes and row output
// Walks lines and positions of each pass, tracks runs and round changes.
// ----------------------------------------------------------------------------
module bit_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bit_pkg::DimW-1:0]     w,
	input  logic [bit_pkg::DimW-1:0]     h,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bit_pkg::IdxW-1:0]     out_num,
	output logic                         out_last,
	output bit_pkg::dp_cmd_t             cmd,
	input  bit_pkg::dp_sts_t             sts
);
	import bit_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;
	logic [DimW-1:0] rows_q, line_q, pos_q;
	logic            run_q, change_q;
	logic [DimW-1:0] nlines, npos, pos_first, pos_nxt;
	logic            rev, vert, pos_ok;
	logic [IdxW-1:0] row_sel, col_sel;

	assign vert      = (phase_q == PH_NORTH) || (phase_q == PH_SOUTH);
	assign rev       = (phase_q == PH_SOUTH) || (phase_q == PH_EAST);
	assign nlines    = vert ? w : h;
	assign npos      = vert ? h : w;
	assign pos_first = rev ? npos - DimW'(2) : DimW'(1);
	assign pos_nxt   = rev ? pos_q - DimW'(1) : pos_q + DimW'(1);
	assign pos_ok     = rev ? (pos_q > DimW'(1)) : (pos_q < npos - DimW'(1));
	assign row_sel   = vert ? pos_q[IdxW-1:0] : line_q[IdxW-1:0];
	assign col_sel   = vert ? line_q[IdxW-1:0] : pos_q[IdxW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.row_sel = row_sel;
		cmd.col_sel = col_sel;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall    = 1'b0;
				cmd.row_sel = rows_q[IdxW-1:0];
				cmd.load_wr = in_valid;
				if (in_valid && (rows_q + DimW'(1) >= h))
					state_d = ST_ROUND;
			end
			ST_ROUND:    state_d = ST_LINE;
			ST_LINE:     state_d = (line_q < nlines - DimW'(1)) ? ST_RD_A : ST_PASS;
			ST_RD_A: begin
				if (!pos_ok)
					state_d = ST_LINE;
				else begin
					cmd.rd_a = 1'b1;
					state_d  = ST_RD_B;
				end
			end
			ST_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_RD_C;
			end
			ST_RD_C: begin
				cmd.rd_c = 1'b1;
				state_d  = ST_RD_W;
			end
			ST_RD_W: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!run_q) begin
					cmd.eval = sts.pix;
				end
				state_d = ST_NEXT;
			end
			ST_NEXT: state_d = ST_RD_A;
			ST_PASS: begin
				if (phase_q == PH_EAST && !change_q)
					state_d = ST_OUT_RD;
				else
					state_d = ST_LINE;
			end
			ST_OUT_RD: begin
				cmd.rd_b    = 1'b1;
				cmd.row_sel = rows_q[IdxW-1:0];
				state_d     = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = out_last ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	assign out_num  = rows_q[IdxW-1:0];
	assign out_last = (rows_q == h - DimW'(1));

	// run tracking: a black pixel opens a run, its evaluation is on the
	// first pixel only; a white pixel (before evaluation) closes the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= '0;
			phase_q  <= PH_NORTH;
			line_q   <= '0;
			pos_q    <= '0;
			run_q    <= 1'b0;
			change_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid)
						rows_q <= (rows_q + DimW'(1) >= h) ? '0 : rows_q + DimW'(1);
					phase_q  <= PH_NORTH;
					change_q <= 1'b0;
					line_q   <= DimW'(1);
				end
				ST_ROUND: begin
					line_q <= DimW'(1);
				end
				ST_LINE: begin
					pos_q <= pos_first;
					run_q <= 1'b0;
				end
				ST_EVAL: begin
					run_q <= sts.pix;
					if (sts.cleared)
						change_q <= 1'b1;
				end
				ST_NEXT: pos_q <= pos_nxt;
				ST_RD_A: begin
					if (!pos_ok)
						line_q <= line_q + DimW'(1);
				end
				ST_PASS: begin
					line_q <= DimW'(1);
					phase_q <= phase_t'(phase_q + 2'd1);
					if (phase_q == PH_EAST)
						change_q <= 1'b0;
				end
				ST_OUT: begin
					if (!out_stall)
						rows_q <= out_last ? '0 : rows_q + DimW'(1);
				end
				default: ;
			endcase
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_stall && out_last) |-> (state_d == ST_LOAD))
		else $error("last row must end frame");
	a_out_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_num))
		else $error("stalled output changed");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> in_stall)
		else $error("input taken while busy");
	a_load_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (rows_q < DimW'(MaxHeight)))
		else $error("load index out of range");

endmodule

@@ hdl/binary_image_thinning.sv @@
// ----------------------------------------------------------------------------
// binary_image_thinning: 3x3 table-driven thinning of a binary image
// Collects image_height rows of up to 64 pixels, thins them in place by
// rounds of north, south, west and east passes, then streams out the rows.
// Usage: write image_width (0x0) and image_height (0x4) over APB while idle.
// Input: one transfer per row on row_bits; rows are not stalled while loading.
// After the last row the input is stalled while the image is thinned. Each
// pixel visit steps through three row reads, a read wait, evaluate and a
// step; thinning runs in rounds until a round changes nothing.
// Output: one transfer per row, row_number 0 first, last_row on the final
// row; each row is read from memory into a register before output. A stalled
// output holds its row. Reset clears the controller and the row count; the
// pixel memory is not cleared and every frame overwrites it.
// ----------------------------------------------------------------------------
module binary_image_thinning (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [63:0] row_bits,
	output logic        valid_out,
	input  logic        stall_out,
	output logic [63:0] thinned_row,
	output logic [5:0]  row_number,
	output logic        last_row
);
	import bit_pkg::*;

	logic [DimW-1:0] width_q, height_q, w, h;
	logic [63:0] mask;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(MaxWidth);
			height_q <= DimW'(MaxHeight);
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				RegWidth:  width_q  <= pwdata[DimW-1:0];
				RegHeight: height_q <= pwdata[DimW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			RegWidth:  prdata = {25'd0, width_q};
			RegHeight: prdata = {25'd0, height_q};
			default:   prdata = '0;
		endcase
	end

	assign w = clamp_dim(width_q, DimW'(MaxWidth));
	assign h = clamp_dim(height_q, DimW'(MaxHeight));
	assign mask = (w >= DimW'(64)) ? '1 : ((64'd1 << w[5:0]) - 64'd1);

	bit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .w(w), .h(h),
		.in_valid(valid_in), .in_stall(stall_in),
		.out_valid(valid_out), .out_stall(stall_out),
		.out_num(row_number), .out_last(last_row),
		.cmd(cmd), .sts(sts)
	);

	bit_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .row_in(row_bits),
		.mask(mask), .sts(sts), .out_row(thinned_row)
	);

endmodule
